>>> src/lkvc_pkg.sv
`timescale 1ns / 1ps
package lkvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int CAP_BITS    = 5;
  localparam int COUNT_BITS  = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_BITS    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RANK_BITS   = IDX_BITS;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic                         command;
    logic signed [KEY_BITS-1:0]   key;
    logic signed [VALUE_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                         found;
    logic signed [VALUE_BITS-1:0] read_value;
  } out_item_t;

  // Head of the request queue as seen by the back end.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } q_head_t;

  // Store occupancy reported by the back end.
  typedef struct packed {
    logic [COUNT_BITS-1:0]  count;
    logic [MAX_ENTRIES-1:0] valid;
  } store_status_t;

endpackage

>>> src/lkvc_front.sv
`timescale 1ns / 1ps
module lkvc_front
  import lkvc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output q_head_t  head,
  input  logic     pop
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);

  in_item_t            slot_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] fill_r, fill_nxt;
  logic                push;
  logic                do_pop;

  assign in_ready = (fill_r != CNT_BITS'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign do_pop   = pop && (fill_r != '0);

  assign head.valid = (fill_r != '0);
  assign head.item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_BITS'(1);
    end
    if (push && !do_pop) begin
      fill_nxt = fill_r + CNT_BITS'(1);
    end else if (do_pop && !push) begin
      fill_nxt = fill_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

>>> src/lkvc_back.sv
`timescale 1ns / 1ps
module lkvc_back
  import lkvc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  input  logic [CAP_BITS-1:0] cfg_data,
  input  q_head_t       head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output out_item_t     out_data,
  output store_status_t status
);

  logic [KEY_BITS-1:0]   key_r   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] val_r   [MAX_ENTRIES];
  logic [RANK_BITS-1:0]  rank_r  [MAX_ENTRIES];
  logic [RANK_BITS-1:0]  rank_nxt[MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt, valid_left;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [CAP_BITS-1:0]   cap_r;
  logic [COUNT_BITS-1:0] eff_cap;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic                  fire;
  logic                  is_put;
  logic                  hit;
  logic [IDX_BITS-1:0]   hit_idx;
  logic [RANK_BITS-1:0]  hit_rank;
  logic [RANK_BITS-1:0]  oldest_rank;
  logic                  need_evict;
  logic                  evict_any;
  logic [IDX_BITS-1:0]   evict_idx;
  logic                  free_any;
  logic [IDX_BITS-1:0]   free_idx;
  logic                  wr_en;
  logic [IDX_BITS-1:0]   wr_idx;
  logic                  wr_key;

  assign fire      = head.valid && (!out_valid_r || out_ready);
  assign pop       = fire;
  assign is_put    = (head.item.command == CMD_PUT);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign status.count = count_r;
  assign status.valid = valid_r;

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = COUNT_BITS'(1);
    end else if (COUNT_BITS'(cap_r) > COUNT_BITS'(MAX_ENTRIES)) begin
      eff_cap = COUNT_BITS'(MAX_ENTRIES);
    end else begin
      eff_cap = COUNT_BITS'(cap_r);
    end
  end

  // Lookup, victim choice and free slot search; each is a priority pick of the lowest index.
  always_comb begin
    hit         = 1'b0;
    hit_idx     = '0;
    evict_any   = 1'b0;
    evict_idx   = '0;
    free_any    = 1'b0;
    free_idx    = '0;
    oldest_rank = RANK_BITS'(count_r - COUNT_BITS'(1));
    need_evict  = (count_r >= eff_cap) && (count_r != '0);
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (key_r[i] == head.item.key)) begin
        hit     = 1'b1;
        hit_idx = IDX_BITS'(i);
      end
      if (valid_r[i] && (rank_r[i] == oldest_rank)) begin
        evict_any = 1'b1;
        evict_idx = IDX_BITS'(i);
      end
    end
    hit_rank   = rank_r[hit_idx];
    valid_left = valid_r;
    if (need_evict && evict_any) begin
      valid_left[evict_idx] = 1'b0;
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_left[i]) begin
        free_any = 1'b1;
        free_idx = IDX_BITS'(i);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_key    = 1'b0;
    wr_idx    = hit_idx;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (fire) begin
      if (hit) begin
        // Entries more recent than the one touched age by one.
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (valid_r[i] && (rank_r[i] < hit_rank)) begin
            rank_nxt[i] = rank_r[i] + RANK_BITS'(1);
          end
        end
        rank_nxt[hit_idx] = '0;
        wr_en = is_put;
      end else if (is_put) begin
        valid_nxt = valid_left;
        count_nxt = count_r - COUNT_BITS'(need_evict && evict_any);
        if (free_any) begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (valid_left[i]) begin
              rank_nxt[i] = rank_r[i] + RANK_BITS'(1);
            end
          end
          rank_nxt[free_idx]  = '0;
          valid_nxt[free_idx] = 1'b1;
          count_nxt = count_r - COUNT_BITS'(need_evict && evict_any) + COUNT_BITS'(1);
          wr_en  = 1'b1;
          wr_key = 1'b1;
          wr_idx = free_idx;
        end
      end
    end
    // A capacity write empties the store and wins over any request.
    if (cfg_valid) begin
      valid_nxt = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      count_r     <= '0;
      cap_r       <= CAP_BITS'(16);
      out_valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_r[i] <= rank_nxt[i];
    end
    if (wr_en) begin
      val_r[wr_idx] <= head.item.value;
      if (wr_key) begin
        key_r[wr_idx] <= head.item.key;
      end
    end
    if (fire) begin
      out_r.found <= hit;
      if (is_put) begin
        out_r.read_value <= head.item.value;
      end else if (hit) begin
        out_r.read_value <= val_r[hit_idx];
      end else begin
        out_r.read_value <= '1;
      end
    end
  end

endmodule

>>> src/lru_key_value_cache_core.sv
`timescale 1ns / 1ps
// LRU key-value cache core, 16 entries, fully associative.
// The back end carries out a request at the head of the queue, and the same edge
// loads the result into the output register. Throughput: one request per cycle
// unless a result waits in the output register untaken; keys are compared in parallel.
// Reset (synchronous, rst_n low): store empty, capacity 16, queue and output empty.
module lru_key_value_cache_core
  import lkvc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CAP_BITS-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data
);

  // The capacity register is always writable. A write also empties the store.
  assign cfg_ready = 1'b1;

  q_head_t       head;
  logic          pop;
  store_status_t status;

  // The front end takes requests into a short queue, so a request can be
  // accepted while the back end waits for its previous result to be taken.
  lkvc_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .head     (head),
    .pop      (pop)
  );

  // The back end carries out one request per cycle unless its last result is still
  // untaken. A get hit or a put of a present key promotes that entry; a put of a new
  // key evicts the least recent entry when the store is full, then inserts.
  lkvc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .status    (status)
  );

  // The entry count always matches the number of valid entries.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(status.valid) == int'(status.count))
    else $error("entry count does not match valid entries");

  // The store never holds more entries than the table has.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(status.count) <= MAX_ENTRIES)
    else $error("entry count exceeds table size");

  // A capacity write leaves the store empty.
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> (status.count == '0) && (status.valid == '0))
    else $error("store not empty after capacity write");

endmodule

>>> dv/lru_key_value_cache_core_tb.sv
`timescale 1ns / 1ps
module lru_key_value_cache_core_tb;
  import lkvc_pkg::*;

  // Cycles waited after the last expected result has come back, to be sure that
  // nothing else is on its way.
  localparam int DRAIN_CYCLES    = 6;
  localparam int TIMEOUT_NS      = 5_000_000;
  localparam int PHASE_REQUESTS  = 180;
  localparam int POOL_MAX        = 24;
  localparam int BACKLOG_CYCLES  = 80;

  localparam logic [KEY_BITS-1:0]   KEY_MIN    = {1'b1, {(KEY_BITS-1){1'b0}}};
  localparam logic [KEY_BITS-1:0]   KEY_MAX    = {1'b0, {(KEY_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VALUE_MIN  = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] VALUE_MAX  = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] MISS_VALUE = '1;

  typedef enum logic {ROW_REQUEST, ROW_CAPACITY} row_kind_t;

  // One line of the directed table. A capacity row writes its value field to
  // the capacity register. Request rows with a typed result carry the
  // expected result right in the table; the rest are checked against the
  // shadow cache.
  typedef struct {
    row_kind_t             kind;
    logic                  command;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    bit                    typed;
    logic                  found;
    logic [VALUE_BITS-1:0] read_value;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 27;

  directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    // Empty store after reset: every lookup misses, also at the most negative key.
    '{ROW_REQUEST, CMD_GET, '0,      '0,            1'b1, 1'b0, MISS_VALUE},
    '{ROW_REQUEST, CMD_GET, KEY_MIN, 32'h1234_5678, 1'b1, 1'b0, MISS_VALUE},
    // Inserts of new keys echo the written value with found low.
    '{ROW_REQUEST, CMD_PUT, KEY_MAX, VALUE_MIN,     1'b1, 1'b0, VALUE_MIN},
    '{ROW_REQUEST, CMD_PUT, KEY_MIN, VALUE_MAX,     1'b1, 1'b0, VALUE_MAX},
    '{ROW_REQUEST, CMD_GET, KEY_MAX, '0,            1'b0, 1'b0, '0},
    '{ROW_REQUEST, CMD_GET, KEY_MIN, '1,            1'b0, 1'b0, '0},
    // Update of a present key: found high, the new value comes back.
    '{ROW_REQUEST, CMD_PUT, KEY_MAX, 32'h5a5a_a5a5, 1'b1, 1'b1, 32'h5a5a_a5a5},
    '{ROW_REQUEST, CMD_GET, KEY_MAX, '0,            1'b0, 1'b0, '0},
    '{ROW_REQUEST, CMD_GET, '1,      '0,            1'b1, 1'b0, MISS_VALUE},
    // Writing the capacity empties the store.
    '{ROW_CAPACITY, CMD_GET, '0,     32'd2,         1'b0, 1'b0, '0},
    '{ROW_REQUEST, CMD_GET, KEY_MAX, '0,            1'b1, 1'b0, MISS_VALUE},
    // Capacity two: touching key 1 leaves key 2 least recent, so it goes.
    '{ROW_REQUEST, CMD_PUT, 32'd1,   32'd10,        1'b1, 1'b0, 32'd10},
    '{ROW_REQUEST, CMD_PUT, 32'd2,   32'd20,        1'b1, 1'b0, 32'd20},
    '{ROW_REQUEST, CMD_GET, 32'd1,   '0,            1'b0, 1'b0, '0},
    '{ROW_REQUEST, CMD_PUT, 32'd3,   32'd30,        1'b1, 1'b0, 32'd30},
    '{ROW_REQUEST, CMD_GET, 32'd2,   '0,            1'b1, 1'b0, MISS_VALUE},
    '{ROW_REQUEST, CMD_GET, 32'd1,   '0,            1'b0, 1'b0, '0},
    '{ROW_REQUEST, CMD_GET, 32'd3,   '0,            1'b0, 1'b0, '0},
    // A capacity of zero behaves as one entry.
    '{ROW_CAPACITY, CMD_GET, '0,     32'd0,         1'b0, 1'b0, '0},
    '{ROW_REQUEST, CMD_PUT, 32'd5,   32'd50,        1'b1, 1'b0, 32'd50},
    '{ROW_REQUEST, CMD_PUT, 32'd6,   32'd60,        1'b1, 1'b0, 32'd60},
    '{ROW_REQUEST, CMD_GET, 32'd5,   '0,            1'b1, 1'b0, MISS_VALUE},
    '{ROW_REQUEST, CMD_GET, 32'd6,   '0,            1'b0, 1'b0, '0},
    // Capacity above the table size saturates; a rewrite of the same value
    // still clears the store.
    '{ROW_CAPACITY, CMD_GET, '0,     32'd31,        1'b0, 1'b0, '0},
    '{ROW_REQUEST, CMD_PUT, 32'd7,   32'd70,        1'b1, 1'b0, 32'd70},
    '{ROW_CAPACITY, CMD_GET, '0,     32'd31,        1'b0, 1'b0, '0},
    '{ROW_REQUEST, CMD_GET, 32'd7,   '0,            1'b1, 1'b0, MISS_VALUE}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CAP_BITS-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;

  lru_key_value_cache_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Shadow copy of the cache contents. Rank 0 is the most recent entry.
  logic [KEY_BITS-1:0]   cached_key [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] cached_val [MAX_ENTRIES];
  bit                    slot_used  [MAX_ENTRIES];
  bit [RANK_BITS-1:0]    slot_rank  [MAX_ENTRIES];
  bit [COUNT_BITS-1:0]   used_count;
  bit [CAP_BITS-1:0]     cap_setting;

  out_item_t pending_results [$];

  // Idling knobs, in percent, set per phase by the main sequence.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // Cycles for which the consumer refuses results; it counts them down.
  int hold_cycles    = 0;

  int requests_sent  = 0;
  int results_seen   = 0;
  int hit_results    = 0;
  int cap_writes     = 0;
  int failures       = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int usable_entries();
    if (cap_setting == 0) return 1;
    if (cap_setting > MAX_ENTRIES) return MAX_ENTRIES;
    return int'(cap_setting);
  endfunction

  function automatic void clear_shadow_store();
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_rank[i] = '0;
    end
    used_count = '0;
  endfunction

  // Applies one request to the shadow cache and returns the result the
  // block must produce for it.
  function automatic out_item_t predict_cache_access(input in_item_t req);
    out_item_t          res;
    int                 hit_slot;
    int                 free_slot;
    bit [RANK_BITS-1:0] hit_rank;
    hit_slot = -1;
    free_slot = -1;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit_slot < 0 && slot_used[i] && cached_key[i] == req.key) hit_slot = i;
    end

    if (hit_slot >= 0) begin
      // Hit: everything more recent than the entry ages by one.
      hit_rank = slot_rank[hit_slot];
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (slot_used[i] && slot_rank[i] < hit_rank) slot_rank[i]++;
      end
      slot_rank[hit_slot] = '0;
      if (req.command == CMD_PUT) cached_val[hit_slot] = req.value;
      res.found = 1'b1;
      res.read_value = cached_val[hit_slot];
      return res;
    end

    res.found = 1'b0;
    if (req.command == CMD_GET) begin
      res.read_value = MISS_VALUE;
      return res;
    end
    res.read_value = req.value;

    // A full store gives up its least recent entry first.
    if (used_count >= usable_entries() && used_count > 0) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (slot_used[i] && slot_rank[i] == used_count - 1) begin
          slot_used[i] = 1'b0;
          used_count--;
          break;
        end
      end
    end

    // The new entry takes the lowest free slot.
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (free_slot < 0 && !slot_used[i]) free_slot = i;
    end
    if (free_slot >= 0) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (slot_used[i]) slot_rank[i]++;
      end
      slot_used[free_slot]  = 1'b1;
      cached_key[free_slot] = req.key;
      cached_val[free_slot] = req.value;
      slot_rank[free_slot]  = '0;
      used_count++;
    end
    return res;
  endfunction

  // Offers one request, idling first at the current rate, and records the
  // expected result once the block has taken it.
  task automatic send_request(input in_item_t req, input bit use_typed,
                              input out_item_t typed_result);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_cache_access(req);
    pending_results.insert(pending_results.size(), use_typed ? typed_result : predicted);
    requests_sent++;
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] setting);
    cfg_valid <= 1'b1;
    cfg_data  <= setting;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cap_setting = setting;
    clear_shadow_store();
    cap_writes++;
  endtask

  // Result side: checks each accepted result against the oldest expectation
  // and then picks out_ready for the next cycle.
  initial begin
    out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: found=%0d read_value=%0d",
                 out_data.found, out_data.read_value);
          failures++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.found) hit_results++;
          if (out_data.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_data.found);
            failures++;
          end
          if (out_data.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d",
                   want.read_value, out_data.read_value);
            failures++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Safety net in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d results still outstanding.", pending_results.size());
    $display("lru_key_value_cache_core regression: fail");
    $finish;
  end

  initial begin
    directed_row_t         row;
    in_item_t              req;
    logic [CAP_BITS-1:0]   phase_caps [9];
    int                    idle_modes [4][2];
    logic [KEY_BITS-1:0]   key_pool [POOL_MAX];
    int                    pool_size;

    phase_caps = '{5'd16, 5'd1, 5'd0, 5'd2, 5'd31, 5'd8, 5'd17, 5'd3,
                   5'($urandom_range(31))};
    // Sender idle percent and receiver stall percent for each idling mode.
    idle_modes = '{'{0, 0}, '{61, 0}, '{0, 61}, '{10, 10}};

    cap_setting = 5'd16;
    clear_shadow_store();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, no idling so that the results are easy to follow.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_CAPACITY) begin
        drain_results();
        write_capacity(row.value[CAP_BITS-1:0]);
      end else begin
        req.command = row.command;
        req.key     = row.key;
        req.value   = row.value;
        send_request(req, row.typed, '{row.found, row.read_value});
      end
    end

    // Random phases: each one sets a new capacity and an idling mode. Keys
    // mostly come from a small pool a little larger than the capacity, so
    // that hits, updates and evictions are all frequent; the rest are fully
    // random keys.
    for (int p = 0; p < 9; p++) begin
      drain_results();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_capacity(phase_caps[p]);

      pool_size = usable_entries() + $urandom_range(1, 6);
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = '0;
      key_pool[3] = '1;
      for (int k = 4; k < POOL_MAX; k++) key_pool[k] = $urandom;

      send_idle_pct  = idle_modes[p % 4][0];
      recv_stall_pct = idle_modes[p % 4][1];
      // In one unthrottled phase the consumer holds off for a long stretch
      // while requests keep coming, which backs the block up to its input.
      if (p == 4) hold_cycles = BACKLOG_CYCLES;

      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        req.command = $urandom_range(1) ? CMD_PUT : CMD_GET;
        if ($urandom_range(99) < 85) req.key = key_pool[$urandom_range(pool_size - 1)];
        else req.key = $urandom;
        req.value = $urandom;
        send_request(req, 1'b0, '0);
      end
    end

    drain_results();

    $display("Sent %0d requests (%0d results, %0d hits) across %0d capacity writes,",
             requests_sent, results_seen, hit_results, cap_writes);
    $display("with idle, stall and consumer back-pressure phases.");
    if (failures == 0) begin
      $display("lru_key_value_cache_core regression: pass");
    end else begin
      $display("lru_key_value_cache_core regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/lkvc_pkg.sv
src/lkvc_front.sv
src/lkvc_back.sv
src/lru_key_value_cache_core.sv
dv/lru_key_value_cache_core_tb.sv
